[hw/rtl/escc_pkg.sv]
package escc_pkg;

  localparam logic [31:0] ResetSeconds = 32'd1451649600;
  localparam logic [7:0]  ResetZone    = 8'h50;
  localparam logic [7:0]  UtcCode      = 8'h30;
  localparam logic [11:0] BaseYear     = 12'd1970;
  localparam logic [11:0] TopYear      = 12'd2106;
  // Only years 1970..2106 reach the calendar walks; the one century year in
  // that span that is not a leap year is 2100.
  localparam logic [11:0] SkipLeapYear = 12'd2100;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SETCAL = 2'd1,
    OP_SETSEC = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CY,     // set-calendar: accumulate year days
    ST_CM,     // set-calendar: accumulate month days
    ST_CT,     // set-calendar: days to seconds plus time of day
    ST_DDAY,   // decode: seconds to days and remainder, sixteen days or one day a step
    ST_DHR,    // decode: hours
    ST_DMIN,   // decode: minutes and seconds
    ST_DYR,    // decode: year walk
    ST_DMON,   // decode: month walk
    ST_DONE
  } state_t;

  function automatic logic leap_year(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != SkipLeapYear);
  endfunction

  function automatic logic [8:0] days_in_year(input logic [11:0] y);
    return leap_year(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1:                      n = leap_year(y) ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/escc_if.sv]
interface escc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] year;
  logic [7:0]  month;
  logic [7:0]  day;
  logic [7:0]  hour;
  logic [7:0]  minute;
  logic [7:0]  second;
  logic [31:0] seconds_value;
  modport source (output valid, operation, year, month, day, hour, minute, second,
                  seconds_value, input ready);
  modport sink (input valid, operation, year, month, day, hour, minute, second,
                seconds_value, output ready);
endinterface

interface escc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_count;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic [5:0]  cal_minute;
  logic [5:0]  cal_second;
  logic [2:0]  weekday;
  logic        rejected;
  modport source (output valid, seconds_count, cal_year, cal_month, cal_day, cal_hour,
                  cal_minute, cal_second, weekday, rejected, input ready);
  modport sink (input valid, seconds_count, cal_year, cal_month, cal_day, cal_hour,
                cal_minute, cal_second, weekday, rejected, output ready);
endinterface

[hw/rtl/epoch_seconds_calendar_clock_unit.sv]
// Channel   Dir  Contents
// in_ch     in   operation, calendar fields, seconds_value
// out_ch    out  seconds count, decoded calendar, weekday, rejected
// cfg       in   cfg_we / cfg_data: timezone_code
//
// Sequence: one shared subtractor walks the decode; days go 16 at a time, then
// singly, then hours, minutes, years and months. Set-calendar first adds up the
// year steps, then the month steps and one step for the sum; an item can also
// wait for as long as out_ch stalls.
// Reset clears the count to 2016-01-01 12:00:00 and the zone to code 80.
// in_ch.ready is high only in IDLE; the result holds in out_ch until taken.
module epoch_seconds_calendar_clock_unit
  import escc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  escc_in_if.sink    in_ch,
  escc_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  state_t state, state_next;

  logic [31:0] epoch_seconds;
  logic [7:0]  tz;
  logic [31:0] acc;      // shared accumulator / remainder
  logic [16:0] days;     // day count
  logic [11:0] yr;
  logic [3:0]  mon;
  logic [4:0]  hr;
  logic [5:0]  mn;
  logic [2:0]  wd;
  logic        rej;
  logic [7:0]  req_mon, req_day, req_hr, req_min, req_sec;
  logic [11:0] req_yr;

  // shared unit: one subtract/compare per cycle
  logic [31:0] sub_k;
  logic [32:0] sub_r;
  always_comb begin
    case (state)
      ST_DDAY: sub_k = (acc >= 32'd1382400) ? 32'd1382400 : 32'd86400;
      ST_DHR:  sub_k = 32'd3600;
      ST_DMIN: sub_k = 32'd60;
      ST_DYR:  sub_k = {23'd0, days_in_year(yr)};
      ST_DMON: sub_k = {27'd0, days_in_month(yr, mon)};
      default: sub_k = 32'd0;
    endcase
    sub_r = {1'b0, acc} - {1'b0, sub_k};
  end
  logic ge;
  assign ge = !sub_r[32];

  logic cal_bad;
  assign cal_bad = in_ch.month < 8'd1 || in_ch.month > 8'd12 || in_ch.day < 8'd1 ||
                   in_ch.day > 8'd31 || in_ch.hour > 8'd23 || in_ch.minute > 8'd59 ||
                   in_ch.year < BaseYear || in_ch.year > TopYear;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid) begin
        state_next = (op_t'(in_ch.operation) == OP_SETCAL && !cal_bad) ? ST_CY : ST_DDAY;
      end
      ST_CY:   if (yr == req_yr) state_next = ST_CM;
      ST_CM:   if (mon == req_mon[3:0] - 4'd1) state_next = ST_CT;
      ST_CT:   state_next = ST_DDAY;
      ST_DDAY: if (!ge) state_next = ST_DHR;
      ST_DHR:  if (!ge) state_next = ST_DMIN;
      ST_DMIN: if (!ge) state_next = ST_DYR;
      ST_DYR:  if (!ge) state_next = ST_DMON;
      ST_DMON: if (!ge || mon == 4'd11) state_next = ST_DONE;
      ST_DONE: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state == ST_IDLE);
    out_ch.valid = (state == ST_DONE);
  end

  logic [31:0] zone_off;
  assign zone_off = (tz >= UtcCode) ? {24'd0, tz - UtcCode} * 32'd900
                                    : 32'd0 - {24'd0, UtcCode - tz} * 32'd900;
  // days of whole years and months, plus the day of month, the time of day and
  // a folded second; wraps modulo 2^32
  logic [31:0] cal_tot;
  assign cal_tot = ({15'd0, days} + {24'd0, req_day} - 32'd1) * 32'd86400 +
                   {24'd0, req_hr} * 32'd3600 + {24'd0, req_min} * 32'd60 +
                   ((req_sec > 8'd59) ? 32'd0 : {24'd0, req_sec});

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      epoch_seconds <= ResetSeconds;
      tz            <= ResetZone;
    end else begin
      state <= state_next;
      if (cfg_we) tz <= cfg_data;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          rej <= (op_t'(in_ch.operation) == OP_SETCAL) && cal_bad;
          req_yr <= in_ch.year; req_mon <= in_ch.month; req_day <= in_ch.day;
          req_hr <= in_ch.hour; req_min <= in_ch.minute; req_sec <= in_ch.second;
          yr <= BaseYear; mon <= 4'd0; days <= 17'd0; wd <= 3'd3;
          unique case (op_t'(in_ch.operation))
            OP_TICK:   begin epoch_seconds <= epoch_seconds + 32'd1;
                             acc <= epoch_seconds + 32'd1; end
            OP_SETCAL: acc <= epoch_seconds;
            OP_SETSEC: begin epoch_seconds <= in_ch.seconds_value + zone_off;
                             acc <= in_ch.seconds_value + zone_off; end
            OP_READ:   acc <= epoch_seconds;
            default:   acc <= epoch_seconds;
          endcase
        end
        ST_CY: if (yr != req_yr) begin
          days <= days + {8'd0, days_in_year(yr)};
          yr   <= yr + 12'd1;
        end
        ST_CM: if (mon != req_mon[3:0] - 4'd1) begin
          days <= days + {12'd0, days_in_month(req_yr, mon)};
          mon  <= mon + 4'd1;
        end
        ST_CT: begin
          epoch_seconds <= cal_tot;
          acc <= cal_tot;
          yr <= BaseYear; mon <= 4'd0; days <= 17'd0;
        end
        ST_DDAY: if (ge) begin
          acc <= sub_r[31:0];
          if (sub_k == 32'd86400) begin
            days <= days + 17'd1;
            wd   <= (wd == 3'd6) ? 3'd0 : wd + 3'd1;
          end else begin
            days <= days + 17'd16;
            wd   <= (wd >= 3'd5) ? wd - 3'd5 : wd + 3'd2;
          end
        end else hr <= 5'd0;
        ST_DHR: if (ge) begin acc <= sub_r[31:0]; hr <= hr + 5'd1; end
                else mn <= 6'd0;
        ST_DMIN: if (ge) begin acc <= sub_r[31:0]; mn <= mn + 6'd1; end
                 else begin acc <= {15'd0, days}; end
        ST_DYR: if (ge) begin acc <= sub_r[31:0]; yr <= yr + 12'd1; end
        ST_DMON: if (ge && mon != 4'd11) begin acc <= sub_r[31:0]; mon <= mon + 4'd1; end
        default: ;
      endcase
    end
  end

  // DMIN leaves seconds in acc before it is reloaded; capture them there
  logic [5:0] sec_q;
  always_ff @(posedge clk) begin
    if (state == ST_DMIN && !ge) sec_q <= acc[5:0];
  end

  always_comb begin
    out_ch.seconds_count = epoch_seconds;
    out_ch.cal_year      = yr;
    out_ch.cal_month     = mon + 4'd1;
    out_ch.cal_day       = acc[4:0] + 5'd1;
    out_ch.cal_hour      = hr;
    out_ch.cal_minute    = mn;
    out_ch.cal_second    = sec_q;
    out_ch.weekday       = wd;
    out_ch.rejected      = rej;
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.seconds_count))
    else $error("result changed while stalled");
  a_wd: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.weekday <= 3'd6)) else $error("weekday range");
  a_mon: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.cal_month >= 4'd1 && out_ch.cal_month <= 4'd12))
    else $error("month range");

endmodule

[sim/epoch_seconds_calendar_clock_unit_tb.sv]
`timescale 1ns / 1ps

module epoch_seconds_calendar_clock_unit_tb;
  import escc_pkg::*;

  // One request as the sender holds it.
  typedef struct {
    op_t         op;
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [31:0] seconds_value;
  } clock_request_t;

  // One readout of the clock: count, calendar, weekday and the reject flag.
  typedef struct {
    logic [31:0] seconds_count;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  cal_hour;
    logic [5:0]  cal_minute;
    logic [5:0]  cal_second;
    logic [2:0]  weekday;
    logic        rejected;
  } clock_readout_t;

  // The slowest item walks the day chunks, single days, hours and minutes plus years, months and set-calendar steps.
  localparam int ItemLatency = 4000;
  localparam longint CycleLimit = 64'd40_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;

  escc_in_if  in_ch ();
  escc_out_if out_ch ();

  epoch_seconds_calendar_clock_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the clock state and the zone register.
  logic [31:0] shadow_seconds = ResetSeconds;
  logic [7:0]  shadow_zone    = ResetZone;

  clock_request_t pending_requests[$];
  clock_readout_t pending_readouts[$];
  int     mismatches = 0;
  longint cycle_count = 0;

  function automatic bit is_leap(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(input int y, input int m0);
    int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    return lens[m0] + ((m0 == 1 && is_leap(y)) ? 1 : 0);
  endfunction

  // Apply one request to the shadow clock and return the readout it should produce.
  function automatic clock_readout_t advance_clock(input clock_request_t r);
    clock_readout_t res;
    longint days_acc;
    longint total;
    int     sec;
    int     zone_off;
    int     days;
    int     rem;
    int     yr;
    int     mo;
    res.rejected = 1'b0;
    case (r.op)
      OP_TICK: shadow_seconds = shadow_seconds + 32'd1;
      OP_SETCAL: begin
        if (r.month < 1 || r.month > 12 || r.day < 1 || r.day > 31 || r.hour > 23 ||
            r.minute > 59 || r.year < BaseYear || r.year > TopYear) begin
          res.rejected = 1'b1;
        end else begin
          // Fold a bad second to zero; let an overlong day carry forward.
          sec = (r.second > 59) ? 0 : int'(r.second);
          days_acc = 0;
          for (int y = 1970; y < int'(r.year); y++) days_acc += is_leap(y) ? 366 : 365;
          for (int m = 0; m + 1 < int'(r.month); m++) days_acc += month_days(r.year, m);
          days_acc += r.day - 1;
          total = days_acc * 86400 + r.hour * 3600 + r.minute * 60 + sec;
          shadow_seconds = total[31:0];
        end
      end
      OP_SETSEC: begin
        zone_off = (int'(shadow_zone) - int'(UtcCode)) * 900;
        shadow_seconds = r.seconds_value + 32'(zone_off);
      end
      default: ;
    endcase

    days = int'(shadow_seconds / 32'd86400);
    rem  = int'(shadow_seconds % 32'd86400);
    res.seconds_count = shadow_seconds;
    res.weekday = 3'((days + 3) % 7);
    yr = 1970;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mo = 0;
    while (mo < 11 && days >= month_days(yr, mo)) begin
      days -= month_days(yr, mo);
      mo++;
    end
    res.cal_year   = 12'(yr);
    res.cal_month  = 4'(mo + 1);
    res.cal_day    = 5'(days + 1);
    res.cal_hour   = 5'(rem / 3600);
    res.cal_minute = 6'((rem % 3600) / 60);
    res.cal_second = 6'(rem % 60);
    return res;
  endfunction

  // Driver: send requests in bursts with random gaps, predict on acceptance.
  clock_request_t held;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) pending_readouts.push_back(advance_clock(held));
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() > 0) begin
        held = pending_requests.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.operation     <= held.op;
        in_ch.year          <= held.year;
        in_ch.month         <= held.month;
        in_ch.day           <= held.day;
        in_ch.hour          <= held.hour;
        in_ch.minute        <= held.minute;
        in_ch.second        <= held.second;
        in_ch.seconds_value <= held.seconds_value;
        if (burst_left <= 1) begin
          // Start a new burst; a third of the time with no gap at all.
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: stall the readout side on its own pattern and check every readout.
  int stall_left = 0;
  int calm_left = 0;

  always @(posedge clk) begin
    clock_readout_t want;
    bit bad;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_readouts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected readout: count %0d", out_ch.seconds_count);
        end else begin
          want = pending_readouts.pop_front();
          bad = (out_ch.seconds_count !== want.seconds_count) ||
                (out_ch.cal_year !== want.cal_year) ||
                (out_ch.cal_month !== want.cal_month) ||
                (out_ch.cal_day !== want.cal_day) ||
                (out_ch.cal_hour !== want.cal_hour) ||
                (out_ch.cal_minute !== want.cal_minute) ||
                (out_ch.cal_second !== want.cal_second) ||
                (out_ch.weekday !== want.weekday) ||
                (out_ch.rejected !== want.rejected);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %0d %0d-%0d-%0d %0d:%0d:%0d wd %0d rej %0d",
                       want.seconds_count, want.cal_year, want.cal_month, want.cal_day,
                       want.cal_hour, want.cal_minute, want.cal_second, want.weekday,
                       want.rejected);
              $display("          got      %0d %0d-%0d-%0d %0d:%0d:%0d wd %0d rej %0d",
                       out_ch.seconds_count, out_ch.cal_year, out_ch.cal_month,
                       out_ch.cal_day, out_ch.cal_hour, out_ch.cal_minute,
                       out_ch.cal_second, out_ch.weekday, out_ch.rejected);
            end
          end
        end
      end
      // Alternate calm stretches with stalls of random length.
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (calm_left > 0) begin
        out_ch.ready <= 1'b1;
        calm_left <= calm_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        calm_left  <= $urandom_range(0, 60);
        stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end
    end
  end

  // Bound the run in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic clock_request_t cal_request(input int y, input int mo, input int d,
                                                  input int h, input int mi, input int s);
    clock_request_t r;
    r.op = OP_SETCAL;
    r.year = 12'(y);
    r.month = 8'(mo);
    r.day = 8'(d);
    r.hour = 8'(h);
    r.minute = 8'(mi);
    r.second = 8'(s);
    r.seconds_value = $urandom();
    return r;
  endfunction

  function automatic clock_request_t op_request(input op_t op, input logic [31:0] value);
    clock_request_t r;
    r = cal_request($urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    r.op = op;
    r.seconds_value = value;
    return r;
  endfunction

  // Queue a random mix: mostly valid set-calendar and set-seconds, plus ticks,
  // reads and malformed calendar requests.
  task automatic queue_random(input int count);
    clock_request_t r;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        r = cal_request($urandom_range(1970, 2106), $urandom_range(1, 12),
                        $urandom_range(1, 31), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 63));
      end else if (pick < 55) begin
        r = op_request(OP_SETSEC, $urandom());
      end else if (pick < 75) begin
        r = op_request(OP_TICK, $urandom());
      end else if (pick < 85) begin
        r = op_request(OP_READ, $urandom());
      end else begin
        r = op_request(OP_SETCAL, $urandom());
      end
      pending_requests.push_back(r);
    end
  endtask

  // Hold until every request is sent and every readout has been checked.
  task automatic drain;
    while (pending_requests.size() > 0 || in_ch.valid || pending_readouts.size() > 0)
      @(posedge clk);
    repeat (ItemLatency) @(posedge clk);
  endtask

  task automatic write_zone(input logic [7:0] code);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_zone = code;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_READ;
    in_ch.year = '0;
    in_ch.month = '0;
    in_ch.day = '0;
    in_ch.hour = '0;
    in_ch.minute = '0;
    in_ch.second = '0;
    in_ch.seconds_value = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset value readout, tick, edges of the count and the calendar.
    pending_requests.push_back(op_request(OP_READ, 32'h0));
    pending_requests.push_back(op_request(OP_TICK, 32'h0));
    pending_requests.push_back(op_request(OP_SETSEC, 32'h0));
    pending_requests.push_back(op_request(OP_SETSEC, 32'hFFFF_FFFF));
    pending_requests.push_back(op_request(OP_TICK, 32'h0));
    pending_requests.push_back(cal_request(1970, 1, 1, 0, 0, 0));
    pending_requests.push_back(cal_request(2106, 2, 7, 6, 28, 15));
    pending_requests.push_back(cal_request(2106, 12, 31, 23, 59, 59));  // wraps
    pending_requests.push_back(cal_request(2000, 2, 29, 12, 30, 30));
    pending_requests.push_back(cal_request(2100, 2, 31, 1, 2, 3));      // day carries
    pending_requests.push_back(cal_request(2023, 6, 15, 10, 20, 60));   // second folds
    pending_requests.push_back(cal_request(2023, 6, 15, 10, 20, 255));
    pending_requests.push_back(cal_request(2023, 0, 15, 10, 20, 5));    // rejects
    pending_requests.push_back(cal_request(2023, 13, 15, 10, 20, 5));
    pending_requests.push_back(cal_request(2023, 6, 0, 10, 20, 5));
    pending_requests.push_back(cal_request(2023, 6, 32, 10, 20, 5));
    pending_requests.push_back(cal_request(2023, 6, 15, 24, 20, 5));
    pending_requests.push_back(cal_request(2023, 6, 15, 10, 60, 5));
    pending_requests.push_back(cal_request(1969, 6, 15, 10, 20, 5));
    pending_requests.push_back(cal_request(2107, 6, 15, 10, 20, 5));
    pending_requests.push_back(cal_request(0, 0, 0, 0, 0, 0));
    pending_requests.push_back(cal_request(4095, 255, 255, 255, 255, 255));
    pending_requests.push_back(op_request(OP_READ, 32'hFFFF_FFFF));
    queue_random(310);
    drain();

    // Walk the zone through UTC, both extremes and a random code.
    write_zone(UtcCode);
    queue_random(330);
    drain();
    write_zone(8'h00);
    pending_requests.push_back(op_request(OP_SETSEC, 32'h0));
    queue_random(330);
    drain();
    write_zone(8'hFF);
    pending_requests.push_back(op_request(OP_SETSEC, 32'hFFFF_FFFF));
    queue_random(330);
    drain();
    write_zone(8'($urandom_range(0, 255)));
    queue_random(330);
    drain();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/escc_pkg.sv
hw/rtl/escc_if.sv
hw/rtl/epoch_seconds_calendar_clock_unit.sv
sim/epoch_seconds_calendar_clock_unit_tb.sv
